[rtl/pdd_pkg.sv]
// Types, codes and position helpers shared by the digram decipher unit.
package pdd_pkg;

    localparam int NUM_CELLS   = 25;
    localparam int NUM_LETTERS = 26;

    localparam logic [4:0] CELL_LIMIT   = 5'd25;
    localparam logic [4:0] LETTER_LIMIT = 5'd26;
    localparam logic [2:0] SIDE_LAST    = 3'd4;
    localparam logic [4:0] SIDE_W       = 5'd5;

    localparam logic [1:0] OP_CLEAR    = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_DECIPHER = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_WROTE = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [4:0] key_position;
        logic [4:0] key_letter;
        logic [4:0] first_letter;
        logic [4:0] second_letter;
        logic       last_pair;
    } t_in_item;

    typedef struct packed {
        logic [4:0] first_plain;
        logic [4:0] second_plain;
        logic [1:0] status;
        logic       last_out;
    } t_out_item;

    typedef struct packed {
        logic       clear;
        logic       write;
        logic [4:0] letter;
        logic [4:0] pos;
        logic [4:0] old_letter;
        logic       prev_hit;
        logic [4:0] prev_pos;
    } t_map_upd;

    typedef struct packed {
        logic       hit_a;
        logic       hit_b;
        logic [4:0] pos_a;
        logic [4:0] pos_b;
    } t_map_look;

    typedef struct packed {
        logic       dec;
        logic       hit;
        logic [1:0] status;
        logic       last_out;
    } t_s2_ctl;

    function automatic logic [2:0] f_row(input logic [4:0] p);
        logic [2:0] r;
        case (p)
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4:      r = 3'd0;
            5'd5, 5'd6, 5'd7, 5'd8, 5'd9:      r = 3'd1;
            5'd10, 5'd11, 5'd12, 5'd13, 5'd14: r = 3'd2;
            5'd15, 5'd16, 5'd17, 5'd18, 5'd19: r = 3'd3;
            5'd20, 5'd21, 5'd22, 5'd23, 5'd24: r = 3'd4;
            default:                           r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] f_col(input logic [4:0] p);
        logic [4:0] c;
        c = p - 5'(f_row(p)) * SIDE_W;
        return c[2:0];
    endfunction

    function automatic logic [2:0] f_back(input logic [2:0] v);
        logic [2:0] r;
        r = (v == 3'd0) ? SIDE_LAST : v - 3'd1;
        return r;
    endfunction

    function automatic logic [4:0] f_cell(input logic [2:0] r, input logic [2:0] c);
        logic [4:0] p;
        p = 5'(r) * SIDE_W + 5'(c);
        return p;
    endfunction

endpackage

[rtl/playfair_digram_decipher_unit.sv]
// Items pass from stage 1 (map read) to stage 2 (key read) to the output register.
// Throughput: one digram or clear per cycle unless i_out_stall holds the output.
// A key write is taken only when both internal stages are empty, and the next
// item waits while the write commits from stage 1 to the two memories.
// Reset clears all valid flags: key square reads as zero, letter map as empty.
module playfair_digram_decipher_unit import pdd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_s2_valid;
    t_s2_ctl   r_s2;
    logic      r_out_valid;
    t_out_item r_out;

    logic      out_free;
    logic      s2_free;
    logic      s1_free;
    logic      s1_go;
    logic      in_ok;
    logic      accept;
    logic      s1_dec;
    logic      s1_wr_ok;
    logic      s1_hit;
    t_s2_ctl   s2_next;
    t_map_look look;
    t_map_upd  upd;
    logic [4:0] cell_a;
    logic [4:0] cell_b;
    logic [4:0] ks_data_a;
    logic [4:0] ks_data_b;
    logic       ks_rd_en_a;
    logic [4:0] ks_rd_addr_a;

    assign out_free = !r_out_valid || !i_out_stall;
    assign s2_free  = !r_s2_valid || out_free;
    assign s1_free  = !r_s1_valid || s2_free;
    assign s1_go    = r_s1_valid && s2_free;

    assign in_ok = s1_free
        && !(r_s1_valid && r_s1_item.operation == OP_WRITE)
        && !(i_in_item.operation == OP_WRITE && (r_s1_valid || r_s2_valid));
    assign accept     = i_in_valid && in_ok;
    assign o_in_stall = !in_ok;

    assign s1_dec   = r_s1_item.operation == OP_DECIPHER;
    assign s1_wr_ok = r_s1_item.operation == OP_WRITE
        && r_s1_item.key_position < CELL_LIMIT
        && r_s1_item.key_letter < LETTER_LIMIT;
    assign s1_hit   = look.hit_a && look.hit_b;

    pdd_letter_map u_map (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_en       (accept),
        .i_rd_letter_a ((i_in_item.operation == OP_WRITE) ? i_in_item.key_letter
                                                          : i_in_item.first_letter),
        .i_rd_letter_b (i_in_item.second_letter),
        .i_upd         (upd),
        .o_look        (look)
    );

    pdd_digram_rule u_rule (
        .i_pos_a  (look.pos_a),
        .i_pos_b  (look.pos_b),
        .o_cell_a (cell_a),
        .o_cell_b (cell_b)
    );

    assign ks_rd_en_a   = (s1_go && s1_dec) || (accept && i_in_item.operation == OP_WRITE);
    assign ks_rd_addr_a = (r_s1_valid && s1_dec) ? cell_a : i_in_item.key_position;

    pdd_key_store u_keys (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en_a   (ks_rd_en_a),
        .i_rd_addr_a (ks_rd_addr_a),
        .i_rd_en_b   (s1_go && s1_dec),
        .i_rd_addr_b (cell_b),
        .i_wr_en     (s1_go && s1_wr_ok),
        .i_wr_addr   (r_s1_item.key_position),
        .i_wr_data   (r_s1_item.key_letter),
        .o_rd_data_a (ks_data_a),
        .o_rd_data_b (ks_data_b)
    );

    always_comb begin
        upd.clear      = s1_go && r_s1_item.operation == OP_CLEAR;
        upd.write      = s1_go && s1_wr_ok;
        upd.letter     = r_s1_item.key_letter;
        upd.pos        = r_s1_item.key_position;
        upd.old_letter = ks_data_a;
        upd.prev_hit   = look.hit_a;
        upd.prev_pos   = look.pos_a;
    end

    always_comb begin
        s2_next.dec      = s1_dec;
        s2_next.hit      = s1_hit;
        s2_next.last_out = s1_dec ? r_s1_item.last_pair : 1'b0;
        if (s1_wr_ok) begin
            s2_next.status = ST_WROTE;
        end else if (s1_dec && !s1_hit) begin
            s2_next.status = ST_MISS;
        end else begin
            s2_next.status = ST_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= accept;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_in_item;
        end
        if (s1_go) begin
            r_s2 <= s2_next;
        end
        if (out_free && r_s2_valid) begin
            r_out.first_plain  <= (r_s2.dec && r_s2.hit) ? ks_data_a : 5'd0;
            r_out.second_plain <= (r_s2.dec && r_s2.hit) ? ks_data_b : 5'd0;
            r_out.status       <= r_s2.status;
            r_out.last_out     <= r_s2.last_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[rtl/pdd_key_store.sv]
// Key square memory: one write port, two registered read ports, written flags.
module pdd_key_store import pdd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rd_en_a,
    input  logic [4:0] i_rd_addr_a,
    input  logic       i_rd_en_b,
    input  logic [4:0] i_rd_addr_b,
    input  logic       i_wr_en,
    input  logic [4:0] i_wr_addr,
    input  logic [4:0] i_wr_data,
    output logic [4:0] o_rd_data_a,
    output logic [4:0] o_rd_data_b
);

    logic [4:0]           r_mem [NUM_CELLS];
    logic [NUM_CELLS-1:0] r_written;
    logic [4:0]           r_data_a;
    logic [4:0]           r_data_b;
    logic                 r_live_a;
    logic                 r_live_b;
    logic [4:0]           addr_a;
    logic [4:0]           addr_b;

    assign addr_a = (i_rd_addr_a < CELL_LIMIT) ? i_rd_addr_a : 5'd0;
    assign addr_b = (i_rd_addr_b < CELL_LIMIT) ? i_rd_addr_b : 5'd0;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en_a) begin
            r_data_a <= r_mem[addr_a];
        end
        if (i_rd_en_b) begin
            r_data_b <= r_mem[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_live_a  <= 1'b0;
            r_live_b  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en_a) begin
                r_live_a <= r_written[addr_a];
            end
            if (i_rd_en_b) begin
                r_live_b <= r_written[addr_b];
            end
        end
    end

    assign o_rd_data_a = r_live_a ? r_data_a : 5'd0;
    assign o_rd_data_b = r_live_b ? r_data_b : 5'd0;

endmodule

[rtl/pdd_letter_map.sv]
// Letter-to-position memory with per-letter valid flags and per-cell owner flags.
module pdd_letter_map import pdd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rd_en,
    input  logic [4:0] i_rd_letter_a,
    input  logic [4:0] i_rd_letter_b,
    input  t_map_upd   i_upd,
    output t_map_look  o_look
);

    logic [4:0]             r_mem [NUM_LETTERS];
    logic [NUM_LETTERS-1:0] r_vld;
    logic [NUM_LETTERS-1:0] n_vld;
    logic [NUM_CELLS-1:0]   r_own;
    logic [NUM_CELLS-1:0]   n_own;
    logic [4:0]             r_pos_a;
    logic [4:0]             r_pos_b;
    logic [4:0]             r_let_a;
    logic [4:0]             r_let_b;
    logic [4:0]             addr_a;
    logic [4:0]             addr_b;
    logic [4:0]             idx_a;
    logic [4:0]             idx_b;

    assign addr_a = (i_rd_letter_a < LETTER_LIMIT) ? i_rd_letter_a : 5'd0;
    assign addr_b = (i_rd_letter_b < LETTER_LIMIT) ? i_rd_letter_b : 5'd0;

    always_ff @(posedge i_clk) begin
        if (i_upd.write) begin
            r_mem[i_upd.letter] <= i_upd.pos;
        end
        if (i_rd_en) begin
            r_pos_a <= r_mem[addr_a];
            r_pos_b <= r_mem[addr_b];
            r_let_a <= i_rd_letter_a;
            r_let_b <= i_rd_letter_b;
        end
    end

    always_comb begin
        n_vld = r_vld;
        n_own = r_own;
        if (i_upd.clear) begin
            n_vld = '0;
            n_own = '0;
        end else if (i_upd.write) begin
            if (r_own[i_upd.pos] && i_upd.old_letter != i_upd.letter &&
                i_upd.old_letter < LETTER_LIMIT) begin
                n_vld[i_upd.old_letter] = 1'b0;
            end
            n_vld[i_upd.letter] = 1'b1;
            if (i_upd.prev_hit && i_upd.prev_pos < CELL_LIMIT) begin
                n_own[i_upd.prev_pos] = 1'b0;
            end
            n_own[i_upd.pos] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_own <= '0;
        end else begin
            r_vld <= n_vld;
            r_own <= n_own;
        end
    end

    assign idx_a = (r_let_a < LETTER_LIMIT) ? r_let_a : 5'd0;
    assign idx_b = (r_let_b < LETTER_LIMIT) ? r_let_b : 5'd0;

    assign o_look.hit_a = (r_let_a < LETTER_LIMIT) && r_vld[idx_a];
    assign o_look.hit_b = (r_let_b < LETTER_LIMIT) && r_vld[idx_b];
    assign o_look.pos_a = r_pos_a;
    assign o_look.pos_b = r_pos_b;

endmodule

[rtl/pdd_digram_rule.sv]
// Playfair decryption rule: maps two square positions to the two plaintext positions.
module pdd_digram_rule import pdd_pkg::*; (
    input  logic [4:0] i_pos_a,
    input  logic [4:0] i_pos_b,
    output logic [4:0] o_cell_a,
    output logic [4:0] o_cell_b
);

    logic [2:0] ra;
    logic [2:0] ca;
    logic [2:0] rb;
    logic [2:0] cb;

    assign ra = f_row(i_pos_a);
    assign ca = f_col(i_pos_a);
    assign rb = f_row(i_pos_b);
    assign cb = f_col(i_pos_b);

    always_comb begin
        if (ra == rb && ca == cb) begin
            o_cell_a = f_cell(f_back(ra), f_back(ca));
            o_cell_b = o_cell_a;
        end else if (ra == rb) begin
            o_cell_a = f_cell(ra, f_back(ca));
            o_cell_b = f_cell(rb, f_back(cb));
        end else if (ca == cb) begin
            o_cell_a = f_cell(f_back(ra), ca);
            o_cell_b = f_cell(f_back(rb), cb);
        end else begin
            o_cell_a = f_cell(ra, cb);
            o_cell_b = f_cell(rb, ca);
        end
    end

endmodule

[tb/sv/playfair_digram_decipher_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the Playfair digram decipher unit: random keys, digrams and noise.
module playfair_digram_decipher_unit_test;
    import pdd_pkg::*;

    localparam int SIDE       = 5;
    localparam int IN_W       = $bits(t_in_item);
    localparam int ITEM_GOAL  = 1700;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 150;
    localparam int CALM_FROM  = 900;
    localparam int CALM_TO    = 1200;
    localparam int IDLE_PCT   = 7;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct {
        t_in_item item;
        bit       drain;
    } t_pend;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    t_pend     cipher_q[$];
    t_out_item plain_q[$];
    t_out_item want;

    logic [4:0] square_model [NUM_CELLS] = '{default: '0};
    logic [5:0] place_model [NUM_LETTERS] = '{default: '0};

    int  items_sent = 0;
    int  errors = 0;
    int  cycles = 0;
    int  hold_left = 0;
    bit  hold_fired = 1'b0;
    logic calm;

    assign calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);

    playfair_digram_decipher_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #1 clk = ~clk;

    function automatic bit find_place(input logic [4:0] letter, output logic [4:0] pos);
        pos = '0;
        if (letter >= LETTER_LIMIT) begin
            return 1'b0;
        end
        pos = place_model[letter][4:0];
        return place_model[letter][5] && (pos < CELL_LIMIT);
    endfunction

    function automatic t_out_item plain_predict(input t_in_item it);
        t_out_item  r;
        logic [4:0] pa, pb, old;
        bit         ha, hb;
        int         ra, ca, rb, cb, ia, ib, l;
        r = '0;
        case (it.operation)
            OP_CLEAR: begin
                for (l = 0; l < NUM_LETTERS; l++) begin
                    place_model[l] = '0;
                end
            end
            OP_WRITE: begin
                if (it.key_position < CELL_LIMIT && it.key_letter < LETTER_LIMIT) begin
                    old = square_model[it.key_position];
                    if (old < LETTER_LIMIT && place_model[old] == {1'b1, it.key_position}) begin
                        place_model[old] = '0;
                    end
                    square_model[it.key_position] = it.key_letter;
                    place_model[it.key_letter] = {1'b1, it.key_position};
                    r.status = ST_WROTE;
                end
            end
            OP_DECIPHER: begin
                r.last_out = it.last_pair;
                ha = find_place(it.first_letter, pa);
                hb = find_place(it.second_letter, pb);
                if (!ha || !hb) begin
                    r.status = ST_MISS;
                end else begin
                    ra = int'(pa) / SIDE;
                    ca = int'(pa) % SIDE;
                    rb = int'(pb) / SIDE;
                    cb = int'(pb) % SIDE;
                    if (ra == rb && ca == cb) begin
                        ia = ((ra + SIDE - 1) % SIDE) * SIDE + (ca + SIDE - 1) % SIDE;
                        ib = ia;
                    end else if (ra == rb) begin
                        ia = ra * SIDE + (ca + SIDE - 1) % SIDE;
                        ib = rb * SIDE + (cb + SIDE - 1) % SIDE;
                    end else if (ca == cb) begin
                        ia = ((ra + SIDE - 1) % SIDE) * SIDE + ca;
                        ib = ((rb + SIDE - 1) % SIDE) * SIDE + cb;
                    end else begin
                        ia = ra * SIDE + cb;
                        ib = rb * SIDE + ca;
                    end
                    r.first_plain  = square_model[ia];
                    r.second_plain = square_model[ib];
                    r.status       = ST_DONE;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_in_item noise_item();
        logic [IN_W-1:0] raw;
        raw = IN_W'($urandom);
        return t_in_item'(raw);
    endfunction

    task automatic push_op(input t_in_item it, input bit drain);
        t_pend p;
        p.item  = it;
        p.drain = drain;
        cipher_q.push_back(p);
    endtask

    task automatic push_clear(input bit drain);
        t_in_item it;
        it = noise_item();
        it.operation = OP_CLEAR;
        push_op(it, drain);
    endtask

    task automatic push_write(input int pos, input int letter);
        t_in_item it;
        it = noise_item();
        it.operation    = OP_WRITE;
        it.key_position = 5'(pos);
        it.key_letter   = 5'(letter);
        push_op(it, 1'b0);
    endtask

    task automatic push_digram(input int c1, input int c2, input bit last);
        t_in_item it;
        it = noise_item();
        it.operation     = OP_DECIPHER;
        it.first_letter  = 5'(c1);
        it.second_letter = 5'(c2);
        it.last_pair     = last;
        push_op(it, 1'b0);
    endtask

    task automatic shuffle(ref int a[26], input int n);
        int i, j, t;
        for (i = n - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = a[i];
            a[i] = a[j];
            a[j] = t;
        end
    endtask

    task automatic key_session();
        int perm[26];
        int order[26];
        int i, k, len, pa, pb, r, c1, c2, n_msg;
        for (i = 0; i < 26; i++) begin
            perm[i]  = i;
            order[i] = i;
        end
        shuffle(perm, 26);
        shuffle(order, 25);
        push_clear($urandom_range(3) == 0);
        for (i = 0; i < NUM_CELLS; i++) begin
            push_write(order[i], perm[order[i]]);
        end
        n_msg = $urandom_range(1, 3);
        repeat (n_msg) begin
            len = $urandom_range(2, 30);
            for (k = 0; k < len; k++) begin
                pa = $urandom_range(NUM_CELLS - 1);
                r  = $urandom_range(99);
                if (r < 25) begin
                    pb = (pa / SIDE) * SIDE + $urandom_range(SIDE - 1);
                end else if (r < 50) begin
                    pb = $urandom_range(SIDE - 1) * SIDE + pa % SIDE;
                end else if (r < 60) begin
                    pb = pa;
                end else begin
                    pb = $urandom_range(NUM_CELLS - 1);
                end
                c1 = perm[pa];
                c2 = perm[pb];
                if ($urandom_range(99) < 2) begin
                    c1 = perm[25];
                end
                if ($urandom_range(99) < 1) begin
                    c2 = $urandom_range(26, 31);
                end
                push_digram(c1, c2, k == len - 1);
            end
        end
    endtask

    task automatic broken_session();
        int n, k;
        n = $urandom_range(1, 10);
        repeat (n) begin
            push_write($urandom_range(0, 26), $urandom_range(0, 27));
        end
        n = $urandom_range(3, 10);
        for (k = 0; k < n; k++) begin
            push_digram($urandom_range(0, 26), $urandom_range(0, 26), k == n - 1);
        end
    endtask

    task automatic check_field(input string name, input int got, input int exp_val);
        if (got != exp_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got);
        end
    endtask

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                plain_q.push_back(plain_predict(in_item));
                items_sent <= items_sent + 1;
            end
            if (!in_valid || !in_stall) begin
                if (cipher_q.size() != 0 && !(cipher_q[0].drain && plain_q.size() != 0)
                        && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    in_valid <= 1'b1;
                    in_item  <= cipher_q[0].item;
                    void'(cipher_q.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left  <= 0;
            hold_fired <= 1'b0;
        end else if (!hold_fired && items_sent >= HOLD_AT) begin
            hold_left  <= HOLD_LEN;
            hold_fired <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (plain_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item, expected none, got %h", $time, out_item);
                end else begin
                    want = plain_q.pop_front();
                    check_field("first_plain", int'(out_item.first_plain),
                                int'(want.first_plain));
                    check_field("second_plain", int'(out_item.second_plain),
                                int'(want.second_plain));
                    check_field("status", int'(out_item.status), int'(want.status));
                    check_field("last_out", int'(out_item.last_out), int'(want.last_out));
                end
            end
            out_stall <= (hold_left != 0) || (!calm && $urandom_range(99) < IDLE_PCT);
        end
    end

    initial begin
        t_in_item it;
        int       r;

        push_digram(0, 25, 1'b1);
        it = '1;
        it.operation = OP_SPARE;
        push_op(it, 1'b0);
        push_write(0, 0);
        push_write(24, 25);
        push_write(25, 3);
        push_write(31, 31);
        push_write(6, 26);
        push_digram(0, 25, 1'b0);
        push_digram(0, 0, 1'b1);
        push_digram(30, 0, 1'b0);
        push_write(1, 1);
        push_digram(0, 1, 1'b0);
        push_write(5, 2);
        push_digram(0, 2, 1'b1);
        push_write(1, 0);
        push_digram(1, 0, 1'b0);
        push_write(0, 3);
        push_digram(0, 3, 1'b1);
        push_clear(1'b1);
        push_digram(0, 3, 1'b0);
        push_digram(3, 24, 1'b1);

        while (cipher_q.size() < ITEM_GOAL) begin
            r = $urandom_range(99);
            if (r < 70) begin
                key_session();
            end else if (r < 85) begin
                broken_session();
            end else begin
                repeat ($urandom_range(3, 12)) push_op(noise_item(), 1'b0);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (cipher_q.size() != 0 || in_valid || plain_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (errors == 0 && plain_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/pdd_pkg.sv
rtl/pdd_key_store.sv
rtl/pdd_letter_map.sv
rtl/pdd_digram_rule.sv
rtl/playfair_digram_decipher_unit.sv
tb/sv/playfair_digram_decipher_unit_test.sv
